FILE: src/mission_upload_sender_macros.svh
// Assertion helpers included by mus_core.
// Both expect clk and rst_n in scope.
`ifndef MISSION_UPLOAD_SENDER_MACROS_SVH
`define MISSION_UPLOAD_SENDER_MACROS_SVH

// Same-cycle implication
`define MUS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define MUS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/mus_pkg.sv
package mus_pkg;

    // Build-time defaults
    localparam int SEQ_BITS_DEF = 16;

    // Event codes (input tuser)
    localparam logic [2:0] EV_START  = 3'd0;
    localparam logic [2:0] EV_TICK   = 3'd1;
    localparam logic [2:0] EV_REQ    = 3'd2;
    localparam logic [2:0] EV_REQINT = 3'd3;
    localparam logic [2:0] EV_ACK    = 3'd4;
    localparam logic [2:0] EV_CANCEL = 3'd5;

    // Outgoing message kinds
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_COUNT = 2'd1;
    localparam logic [1:0] KIND_ITEM  = 2'd2;
    localparam logic [1:0] KIND_ACK   = 2'd3;

    // Ack codes we send
    localparam logic [3:0] ACK_UNSUPPORTED = 4'd3;
    localparam logic [3:0] ACK_CANCELLED   = 4'd15;

    // Ack codes we receive (standard numbering)
    localparam logic [3:0] RX_ACCEPTED     = 4'd0;
    localparam logic [3:0] RX_ERROR        = 4'd1;
    localparam logic [3:0] RX_UNSUP_FRAME  = 4'd2;
    localparam logic [3:0] RX_UNSUPPORTED  = 4'd3;
    localparam logic [3:0] RX_NO_SPACE     = 4'd4;
    localparam logic [3:0] RX_LAST_PARAM   = 4'd12;
    localparam logic [3:0] RX_INVALID_SEQ  = 4'd13;
    localparam logic [3:0] RX_DENIED       = 4'd14;

    // Final results
    localparam logic [3:0] RES_NONE        = 4'd0;
    localparam logic [3:0] RES_OK          = 4'd1;
    localparam logic [3:0] RES_LINK        = 4'd2;
    localparam logic [3:0] RES_TIMEOUT     = 4'd3;
    localparam logic [3:0] RES_PROTOCOL    = 4'd4;
    localparam logic [3:0] RES_FRAME       = 4'd5;
    localparam logic [3:0] RES_UNSUPPORTED = 4'd6;
    localparam logic [3:0] RES_NOSPACE     = 4'd7;
    localparam logic [3:0] RES_PARAM       = 4'd8;
    localparam logic [3:0] RES_SEQUENCE    = 4'd9;
    localparam logic [3:0] RES_DENIED      = 4'd10;
    localparam logic [3:0] RES_CANCELLED   = 4'd11;

    // Configuration register indexes
    localparam int CFG_ADDR_BITS = 3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_ITEM_COUNT    = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MISSION_TYPE  = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_TARGET_SYS    = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_TARGET_COMP   = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_RETRY_LIMIT   = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_TIMEOUT_TICKS = 3'd5;
    localparam int CFG_DATA_BITS = 16;

    // Register reset values
    localparam logic [7:0]  RETRY_LIMIT_RST   = 8'd5;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

    // Word widths
    localparam int IN_TDATA_BITS  = 40;
    localparam int OUT_TDATA_BITS = 48;

    typedef struct packed {
        logic [15:0] item_count;
        logic [7:0]  msn_kind;
        logic [7:0]  peer_sys;
        logic [7:0]  peer_comp;
        logic [7:0]  retry_limit;
        logic [15:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  msg_kind;
        logic [15:0] msg_seq;
        logic [3:0]  msg_ack_code;
        logic [7:0]  msg_dest_system;
        logic [7:0]  msg_dest_component;
        logic        done_res;
        logic [3:0]  result_code;
    } res_t;

    // Map a received ack code to a final result
    function automatic logic [3:0] map_ack(input logic [3:0] code, input logic all_sent);
        logic [3:0] r;
        begin
            if (code == RX_ACCEPTED)
                r = all_sent ? RES_OK : RES_PROTOCOL;
            else if (code == RX_ERROR)
                r = RES_PROTOCOL;
            else if (code == RX_UNSUP_FRAME)
                r = RES_FRAME;
            else if (code == RX_UNSUPPORTED)
                r = RES_UNSUPPORTED;
            else if (code == RX_NO_SPACE)
                r = RES_NOSPACE;
            else if (code <= RX_LAST_PARAM)
                r = RES_PARAM;
            else if (code == RX_INVALID_SEQ)
                r = RES_SEQUENCE;
            else if (code == RX_DENIED)
                r = RES_DENIED;
            else
                r = RES_CANCELLED;
            return r;
        end
    endfunction

endpackage

FILE: src/mus_cfg.sv
module mus_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mus_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [mus_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    output mus_pkg::cfg_t                       cfg
);
    import mus_pkg::*;

    cfg_t cfg_reg;

    // Register file, write only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.item_count    <= '0;
            cfg_reg.msn_kind      <= '0;
            cfg_reg.peer_sys      <= '0;
            cfg_reg.peer_comp     <= '0;
            cfg_reg.retry_limit   <= RETRY_LIMIT_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_ITEM_COUNT:    cfg_reg.item_count    <= cfg_wdata;
                CFG_MISSION_TYPE:  cfg_reg.msn_kind      <= cfg_wdata[7:0];
                CFG_TARGET_SYS:    cfg_reg.peer_sys      <= cfg_wdata[7:0];
                CFG_TARGET_COMP:   cfg_reg.peer_comp     <= cfg_wdata[7:0];
                CFG_RETRY_LIMIT:   cfg_reg.retry_limit   <= cfg_wdata[7:0];
                CFG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/mus_core.sv
module mus_core #(
    parameter int SEQ_BITS = mus_pkg::SEQ_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  mus_pkg::cfg_t cfg,
    input  logic          ev_accept,
    input  logic [2:0]    req_type,
    input  logic [15:0]   req_seq,
    input  logic [3:0]    ack_type,
    input  logic [7:0]    src_system,
    input  logic [7:0]    src_component,
    input  logic          send_refused,
    output mus_pkg::res_t res
);
    import mus_pkg::*;

    logic                active_reg, active_next;
    logic                phase_reg, phase_next;
    logic [SEQ_BITS-1:0] next_index_reg, next_index_next;
    logic [7:0]          retry_reg, retry_next;
    logic [15:0]         timer_reg, timer_next;
    logic                armed_reg, armed_next;

    logic [SEQ_BITS-1:0] seq;
    logic [15:0]         idx16;
    logic [15:0]         seq16;
    logic                exhausted;
    logic [7:0]          retry_base;
    logic [7:0]          retry_base_inc;
    logic [7:0]          retry_inc;

    assign seq       = req_seq[SEQ_BITS-1:0];
    assign idx16     = 16'(next_index_reg);
    assign seq16     = 16'(seq);
    assign exhausted = (retry_reg >= cfg.retry_limit);

    // Saturating retry bumps: from the held count and from the request base
    assign retry_inc      = (retry_reg == 8'hFF) ? retry_reg : retry_reg + 8'd1;
    assign retry_base     = (next_index_reg == seq) ? 8'd0 : retry_reg;
    assign retry_base_inc = (retry_base == 8'hFF) ? retry_base : retry_base + 8'd1;

    // Event handling: next state and the result word
    always_comb
    begin
        active_next     = active_reg;
        phase_next      = phase_reg;
        next_index_next = next_index_reg;
        retry_next      = retry_reg;
        timer_next      = timer_reg;
        armed_next      = armed_reg;
        res             = '0;

        case (req_type)
            EV_START:
            begin
                active_next     = 1'b1;
                phase_next      = 1'b0;
                next_index_next = '0;
                retry_next      = 8'd0;
                timer_next      = cfg.timeout_ticks;
                armed_next      = 1'b1;
                if (send_refused)
                begin
                    active_next     = 1'b0;
                    armed_next      = 1'b0;
                    timer_next      = '0;
                    res.done_res    = 1'b1;
                    res.result_code = RES_LINK;
                end
                else
                begin
                    res.msg_kind           = KIND_COUNT;
                    res.msg_seq            = cfg.item_count;
                    res.msg_dest_system    = cfg.peer_sys;
                    res.msg_dest_component = cfg.peer_comp;
                    retry_next             = 8'd1;
                end
            end

            EV_TICK:
            begin
                if (active_reg && armed_reg)
                begin
                    if (timer_reg > 16'd1)
                        timer_next = timer_reg - 16'd1;
                    else if (exhausted)
                    begin
                        active_next     = 1'b0;
                        armed_next      = 1'b0;
                        timer_next      = '0;
                        res.done_res    = 1'b1;
                        res.result_code = RES_TIMEOUT;
                    end
                    else
                    begin
                        timer_next = cfg.timeout_ticks;
                        armed_next = 1'b1;
                        if (phase_reg)
                            retry_next = retry_inc;
                        else if (send_refused)
                        begin
                            active_next     = 1'b0;
                            armed_next      = 1'b0;
                            timer_next      = '0;
                            res.done_res    = 1'b1;
                            res.result_code = RES_LINK;
                        end
                        else
                        begin
                            // resend the count
                            res.msg_kind           = KIND_COUNT;
                            res.msg_seq            = cfg.item_count;
                            res.msg_dest_system    = cfg.peer_sys;
                            res.msg_dest_component = cfg.peer_comp;
                            retry_next             = retry_inc;
                        end
                    end
                end
            end

            EV_REQ:
            begin
                if (active_reg)
                begin
                    if (send_refused)
                    begin
                        active_next     = 1'b0;
                        armed_next      = 1'b0;
                        timer_next      = '0;
                        res.done_res    = 1'b1;
                        res.result_code = RES_LINK;
                    end
                    else
                    begin
                        // legacy request: unsupported, back to the requester
                        res.msg_kind           = KIND_ACK;
                        res.msg_ack_code       = ACK_UNSUPPORTED;
                        res.msg_dest_system    = src_system;
                        res.msg_dest_component = src_component;
                        timer_next             = cfg.timeout_ticks;
                        armed_next             = 1'b1;
                    end
                end
            end

            EV_REQINT:
            begin
                if (active_reg)
                begin
                    phase_next = 1'b1;
                    // requests ahead of the expected index only switch the phase
                    if (next_index_reg >= seq)
                    begin
                        if (next_index_reg > seq && exhausted)
                        begin
                            active_next     = 1'b0;
                            armed_next      = 1'b0;
                            timer_next      = '0;
                            res.done_res    = 1'b1;
                            res.result_code = RES_TIMEOUT;
                        end
                        else
                        begin
                            retry_next      = retry_base;
                            timer_next      = cfg.timeout_ticks;
                            armed_next      = 1'b1;
                            next_index_next = seq;
                            if (seq16 < cfg.item_count)
                            begin
                                if (send_refused)
                                begin
                                    active_next     = 1'b0;
                                    armed_next      = 1'b0;
                                    timer_next      = '0;
                                    res.done_res    = 1'b1;
                                    res.result_code = RES_LINK;
                                end
                                else
                                begin
                                    res.msg_kind           = KIND_ITEM;
                                    res.msg_seq            = seq16;
                                    res.msg_dest_system    = cfg.peer_sys;
                                    res.msg_dest_component = cfg.peer_comp;
                                    next_index_next        = seq + SEQ_BITS'(1);
                                    retry_next             = retry_base_inc;
                                end
                            end
                        end
                    end
                end
            end

            EV_ACK:
            begin
                if (active_reg)
                begin
                    active_next     = 1'b0;
                    armed_next      = 1'b0;
                    timer_next      = '0;
                    res.done_res    = 1'b1;
                    res.result_code = map_ack(ack_type, idx16 == cfg.item_count);
                end
            end

            EV_CANCEL:
            begin
                if (active_reg)
                begin
                    active_next     = 1'b0;
                    armed_next      = 1'b0;
                    timer_next      = '0;
                    res.done_res    = 1'b1;
                    if (send_refused)
                        res.result_code = RES_LINK;
                    else
                    begin
                        res.msg_kind           = KIND_ACK;
                        res.msg_ack_code       = ACK_CANCELLED;
                        res.msg_dest_system    = cfg.peer_sys;
                        res.msg_dest_component = cfg.peer_comp;
                        res.result_code        = RES_CANCELLED;
                    end
                end
            end

            default: ;
        endcase
    end

    // Transfer state, updated once per accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            phase_reg      <= 1'b0;
            next_index_reg <= '0;
            retry_reg      <= '0;
            timer_reg      <= '0;
            armed_reg      <= 1'b0;
        end
        else if (ev_accept)
        begin
            active_reg     <= active_next;
            phase_reg      <= phase_next;
            next_index_reg <= next_index_next;
            retry_reg      <= retry_next;
            timer_reg      <= timer_next;
            armed_reg      <= armed_next;
        end
    end

`include "mission_upload_sender_macros.svh"

    `MUS_ASSERT_NOW(a_armed_only_active, !active_reg,
        !armed_reg && timer_reg == 16'd0, "timer running while idle")
    `MUS_ASSERT_NEXT(a_done_goes_idle, ev_accept && res.done_res,
        !active_reg, "transfer still active after done")
    `MUS_ASSERT_NEXT(a_start_arms, ev_accept && req_type == EV_START && !send_refused,
        active_reg && armed_reg && !phase_reg && retry_reg == 8'd1,
        "start did not open count phase")
    `MUS_ASSERT_NOW(a_idle_silent, ev_accept && !active_reg && req_type != EV_START,
        res == '0, "result from idle block")

endmodule

FILE: src/mus_obuf.sv
module mus_obuf (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  mus_pkg::res_t in_res,
    output logic          out_valid,
    input  logic          out_ready,
    output mus_pkg::res_t out_res
);
    import mus_pkg::*;

    logic valid_reg;
    res_t res_reg;

    // Take a new word when empty or when the held word leaves this cycle
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            res_reg <= in_res;
    end

endmodule

FILE: src/mission_upload_sender.sv
// Mission upload sender: takes one event word per cycle on the s_ side and
// returns exactly one result word per event on the m_ side, in the cycle after
// the event is taken. The decision logic sits between the accepted event and
// a single output register, so throughput is one event per cycle whenever the
// output register is empty or is being drained in the same cycle; a stalled
// m_ side holds at most one finished word and backpressures s_ through
// s_tready. Write the configuration registers only while no transfer word is
// in flight. Item payloads are not handled here: an item message carries
// only its index in msg_seq.
module mission_upload_sender #(
    parameter int SEQ_BITS = mus_pkg::SEQ_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_we,
    input  logic [mus_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  logic [mus_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    // event words
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // req_seq[15:0], ack_type[19:16], src_system[27:20], src_component[35:28],
    // send_refused[36], zero fill[39:37]
    input  logic [mus_pkg::IN_TDATA_BITS-1:0]    s_tdata,
    // req_type[2:0]
    input  logic [2:0]                           s_tuser,
    // result words
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // msg_kind[1:0], msg_seq[17:2], msg_ack_code[21:18], msg_dest_system[29:22],
    // msg_dest_component[37:30], result_code[41:38], zero fill[47:42]
    output logic [mus_pkg::OUT_TDATA_BITS-1:0]   m_tdata,
    // done_res
    output logic                                 m_tlast
);
    import mus_pkg::*;

    cfg_t cfg;
    res_t core_res;
    res_t out_res;
    logic ev_accept;

    assign ev_accept = s_tvalid && s_tready;

    mus_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mus_core #(
        .SEQ_BITS (SEQ_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .ev_accept     (ev_accept),
        .req_type      (s_tuser),
        .req_seq       (s_tdata[15:0]),
        .ack_type      (s_tdata[19:16]),
        .src_system    (s_tdata[27:20]),
        .src_component (s_tdata[35:28]),
        .send_refused  (s_tdata[36]),
        .res           (core_res)
    );

    mus_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_res    (core_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Pack the result word
    assign m_tdata = {6'd0, out_res.result_code, out_res.msg_dest_component,
                      out_res.msg_dest_system, out_res.msg_ack_code,
                      out_res.msg_seq, out_res.msg_kind};
    assign m_tlast = out_res.done_res;

endmodule

FILE: dv/mission_upload_sender_tb.sv
`timescale 1ns / 1ps

module mission_upload_sender_tb;
    import mus_pkg::*;

    // Event codes the block must ignore
    localparam logic [2:0] EV_RSVD_A = 3'd6;
    localparam logic [2:0] EV_RSVD_B = 3'd7;

    // One event word as the partner side sees it
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] seq;
        logic [3:0]  ack;
        logic [7:0]  src_sys;
        logic [7:0]  src_comp;
        logic        refused;
    } upl_ev_t;

    typedef struct packed {
        upl_ev_t ev;
        logic    typed;
        res_t    want;
    } dir_row_t;

    localparam res_t NO_MSG   = '0;
    localparam res_t LINK_END = '{KIND_NONE, 16'd0, 4'd0, 8'd0, 8'd0, 1'b1, RES_LINK};

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0]   cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0]   cfg_wdata = '0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [IN_TDATA_BITS-1:0]   s_tdata = '0;
    logic [2:0]                 s_tuser = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0]  m_tdata;
    logic                       m_tlast;

    mission_upload_sender dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    // Run limit
    initial
    begin
        #(5_000_000);
        $display("TEST FAILED");
        $finish;
    end

    // Predictor copy of the registers
    logic [15:0] cfg_items     = '0;
    logic [7:0]  cfg_mtype     = '0;
    logic [7:0]  cfg_tsys      = '0;
    logic [7:0]  cfg_tcomp     = '0;
    logic [7:0]  cfg_retry_lim = RETRY_LIMIT_RST;
    logic [15:0] cfg_timeout   = TIMEOUT_TICKS_RST;

    // Predictor copy of the transfer state
    logic        sess_active = 1'b0;
    logic        item_phase  = 1'b0;
    logic [15:0] next_idx    = '0;
    logic [7:0]  retries     = '0;
    logic [15:0] timer_left  = '0;
    logic        timer_armed = 1'b0;

    res_t awaited_msgs[$];
    int   bad_words = 0;
    int   words_sent = 0;
    int   src_gap_pct = 14;
    int   sink_stall_pct = 45;

    // Random field values
    function automatic logic [15:0] any_seq();
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [3:0] any_ack();
        return 4'($urandom_range(0, 15));
    endfunction

    function automatic logic [7:0] any_id();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void bump_retries();
        if (retries != 8'hFF)
            retries = retries + 8'd1;
    endfunction

    function automatic void arm_timer();
        timer_left  = cfg_timeout;
        timer_armed = 1'b1;
    endfunction

    function automatic res_t close_transfer(input res_t r, input logic [3:0] code);
        sess_active   = 1'b0;
        timer_armed   = 1'b0;
        timer_left    = '0;
        r.done_res    = 1'b1;
        r.result_code = code;
        return r;
    endfunction

    function automatic res_t announce_count(input logic refused);
        res_t r;
        r = '0;
        if (refused)
            return close_transfer(r, RES_LINK);
        r.msg_kind           = KIND_COUNT;
        r.msg_seq            = cfg_items;
        r.msg_dest_system    = cfg_tsys;
        r.msg_dest_component = cfg_tcomp;
        bump_retries();
        return r;
    endfunction

    // Final result for an ack received from the partner
    function automatic logic [3:0] ack_result(input logic [3:0] code);
        case (code)
            RX_ACCEPTED:    return (next_idx == cfg_items) ? RES_OK : RES_PROTOCOL;
            RX_ERROR:       return RES_PROTOCOL;
            RX_UNSUP_FRAME: return RES_FRAME;
            RX_UNSUPPORTED: return RES_UNSUPPORTED;
            RX_NO_SPACE:    return RES_NOSPACE;
            RX_INVALID_SEQ: return RES_SEQUENCE;
            RX_DENIED:      return RES_DENIED;
            ACK_CANCELLED:  return RES_CANCELLED;
            default:        return RES_PARAM;
        endcase
    endfunction

    // Expected result word for one event; advances the predictor state
    function automatic res_t upload_step(input upl_ev_t ev);
        res_t r;
        r = '0;
        if (ev.kind == EV_START)
        begin
            sess_active = 1'b1;
            item_phase  = 1'b0;
            retries     = '0;
            next_idx    = '0;
            arm_timer();
            return announce_count(ev.refused);
        end
        if (!sess_active || ev.kind > EV_CANCEL)
            return r;
        case (ev.kind)
            EV_TICK:
            begin
                if (timer_armed)
                begin
                    if (timer_left > 16'd1)
                        timer_left = timer_left - 16'd1;
                    else if (retries >= cfg_retry_lim)
                        r = close_transfer(r, RES_TIMEOUT);
                    else
                    begin
                        arm_timer();
                        if (!item_phase)
                            r = announce_count(ev.refused);
                        else
                            bump_retries();
                    end
                end
            end
            EV_REQ:
            begin
                if (ev.refused)
                    r = close_transfer(r, RES_LINK);
                else
                begin
                    r.msg_kind           = KIND_ACK;
                    r.msg_ack_code       = ACK_UNSUPPORTED;
                    r.msg_dest_system    = ev.src_sys;
                    r.msg_dest_component = ev.src_comp;
                    arm_timer();
                end
            end
            EV_REQINT:
            begin
                item_phase = 1'b1;
                // requests ahead of the expected index only switch the phase
                if (next_idx >= ev.seq)
                begin
                    if (next_idx > ev.seq && retries >= cfg_retry_lim)
                        r = close_transfer(r, RES_TIMEOUT);
                    else
                    begin
                        if (next_idx == ev.seq)
                            retries = '0;
                        arm_timer();
                        next_idx = ev.seq;
                        if (next_idx < cfg_items)
                        begin
                            if (ev.refused)
                                r = close_transfer(r, RES_LINK);
                            else
                            begin
                                r.msg_kind           = KIND_ITEM;
                                r.msg_seq            = next_idx;
                                r.msg_dest_system    = cfg_tsys;
                                r.msg_dest_component = cfg_tcomp;
                                next_idx = next_idx + 16'd1;
                                bump_retries();
                            end
                        end
                    end
                end
            end
            EV_ACK:
                r = close_transfer(r, ack_result(ev.ack));
            default:
            begin
                if (ev.refused)
                    r = close_transfer(r, RES_LINK);
                else
                begin
                    r.msg_kind           = KIND_ACK;
                    r.msg_ack_code       = ACK_CANCELLED;
                    r.msg_dest_system    = cfg_tsys;
                    r.msg_dest_component = cfg_tcomp;
                    r = close_transfer(r, RES_CANCELLED);
                end
            end
        endcase
        return r;
    endfunction

    // Register write; called at a falling edge while the block is idle
    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_ITEM_COUNT:    cfg_items     = val;
            CFG_MISSION_TYPE:  cfg_mtype     = val[7:0];
            CFG_TARGET_SYS:    cfg_tsys      = val[7:0];
            CFG_TARGET_COMP:   cfg_tcomp     = val[7:0];
            CFG_RETRY_LIMIT:   cfg_retry_lim = val[7:0];
            CFG_TIMEOUT_TICKS: cfg_timeout   = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_setup(input logic [15:0] items, input logic [7:0] mtype,
                              input logic [7:0] tsys, input logic [7:0] tcomp,
                              input logic [7:0] rlim, input logic [15:0] tmo);
        write_reg(CFG_ITEM_COUNT, items);
        write_reg(CFG_MISSION_TYPE, {8'h00, mtype});
        write_reg(CFG_TARGET_SYS, {8'h00, tsys});
        write_reg(CFG_TARGET_COMP, {8'h00, tcomp});
        write_reg(CFG_RETRY_LIMIT, {8'h00, rlim});
        write_reg(CFG_TIMEOUT_TICKS, tmo);
    endtask

    // Present one word from a falling edge; returns at the falling edge after it
    // was taken, with tvalid still high so the next word can follow back to back
    task automatic drive_event(input upl_ev_t ev, input logic use_typed = 1'b0,
                               input res_t typed_res = '0);
        res_t r;
        while ($urandom_range(0, 99) < src_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ev.kind;
        s_tdata  <= {3'b000, ev.refused, ev.src_comp, ev.src_sys, ev.ack, ev.seq};
        do
            @(posedge clk);
        while (!s_tready);
        r = upload_step(ev);
        awaited_msgs.insert(awaited_msgs.size(), use_typed ? typed_res : r);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_rand(input logic [2:0] kind, input logic [15:0] seq,
                             input logic [3:0] ack);
        upl_ev_t ev;
        ev.kind     = kind;
        ev.seq      = seq;
        ev.ack      = ack;
        ev.src_sys  = any_id();
        ev.src_comp = any_id();
        ev.refused  = ($urandom_range(0, 29) == 0);
        drive_event(ev);
    endtask

    // Stop sending and wait until every expected word has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (awaited_msgs.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    // One well-formed upload with random detours
    task automatic run_session();
        int n;
        n = (cfg_items > 16'd12) ? 12 : int'(cfg_items);
        send_rand(EV_START, any_seq(), any_ack());
        for (int i = 0; i <= n; i++)
        begin
            repeat ($urandom_range(0, 2))
                send_rand(EV_TICK, any_seq(), any_ack());
            case ($urandom_range(0, 15))
                0: if (i > 0) send_rand(EV_REQINT, 16'(i - 1), any_ack());
                1: send_rand(EV_REQINT, 16'(i + int'($urandom_range(1, 3))), any_ack());
                2: send_rand(EV_REQ, any_seq(), any_ack());
                default: ;
            endcase
            send_rand(EV_REQINT, 16'(i), any_ack());
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: send_rand(EV_ACK, any_seq(), RX_ACCEPTED);
            5, 6:          send_rand(EV_ACK, any_seq(), any_ack());
            7:             send_rand(EV_CANCEL, any_seq(), any_ack());
            default:
                repeat ($urandom_range(4, 24))
                    send_rand(EV_TICK, any_seq(), any_ack());
        endcase
    endtask

    // Directed words; typed results only where they are obvious
    dir_row_t directed_rows[$] = '{
        '{'{EV_TICK,   16'h0000, 4'h0, 8'h00, 8'h00, 1'b0}, 1'b1, NO_MSG},
        '{'{EV_RSVD_A, 16'hFFFF, 4'hF, 8'hFF, 8'hFF, 1'b1}, 1'b1, NO_MSG},
        '{'{EV_START,  16'h0000, 4'h0, 8'h00, 8'h00, 1'b1}, 1'b1, LINK_END},
        '{'{EV_START,  16'h0000, 4'h0, 8'h00, 8'h00, 1'b0}, 1'b0, NO_MSG},
        '{'{EV_RSVD_B, 16'h0000, 4'h0, 8'h00, 8'h00, 1'b0}, 1'b1, NO_MSG},
        '{'{EV_REQ,    16'h0000, 4'h0, 8'hFF, 8'hFF, 1'b0}, 1'b0, NO_MSG},
        '{'{EV_TICK,   16'h0000, 4'h0, 8'h00, 8'h00, 1'b0}, 1'b0, NO_MSG},
        '{'{EV_TICK,   16'h0000, 4'h0, 8'h00, 8'h00, 1'b0}, 1'b0, NO_MSG},
        '{'{EV_CANCEL, 16'h0000, 4'hF, 8'h00, 8'h00, 1'b1}, 1'b1, LINK_END},
        '{'{EV_START,  16'h0000, 4'h0, 8'h00, 8'h00, 1'b0}, 1'b0, NO_MSG},
        '{'{EV_REQINT, 16'hFFFF, 4'h0, 8'h00, 8'h00, 1'b0}, 1'b0, NO_MSG},
        '{'{EV_REQINT, 16'h0000, 4'h0, 8'h00, 8'h00, 1'b0}, 1'b0, NO_MSG},
        '{'{EV_REQINT, 16'h0000, 4'h0, 8'h00, 8'h00, 1'b0}, 1'b0, NO_MSG},
        '{'{EV_REQINT, 16'h0001, 4'h0, 8'h00, 8'h00, 1'b0}, 1'b0, NO_MSG},
        '{'{EV_REQINT, 16'h0002, 4'h0, 8'h00, 8'h00, 1'b1}, 1'b1, LINK_END},
        '{'{EV_START,  16'h0000, 4'h0, 8'h00, 8'h00, 1'b0}, 1'b0, NO_MSG},
        '{'{EV_REQINT, 16'h0000, 4'h0, 8'h00, 8'h00, 1'b0}, 1'b0, NO_MSG},
        '{'{EV_REQINT, 16'h0001, 4'h0, 8'h00, 8'h00, 1'b0}, 1'b0, NO_MSG},
        '{'{EV_REQINT, 16'h0002, 4'h0, 8'h00, 8'h00, 1'b0}, 1'b0, NO_MSG},
        '{'{EV_REQINT, 16'h0003, 4'h0, 8'h00, 8'h00, 1'b0}, 1'b0, NO_MSG},
        '{'{EV_ACK,    16'h0000, 4'h0, 8'h00, 8'h00, 1'b0}, 1'b0, NO_MSG},
        '{'{EV_START,  16'h0000, 4'h0, 8'h00, 8'h00, 1'b0}, 1'b0, NO_MSG},
        '{'{EV_CANCEL, 16'h0000, 4'h0, 8'h00, 8'h00, 1'b0}, 1'b0, NO_MSG}
    };

    // Receiver backpressure
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

    task automatic note_fault(input string what, input res_t want, input res_t got);
        bad_words++;
        if (bad_words <= 10)
            $display("%0t %s: exp kind %0d seq %0d ack %0d dst %0d/%0d done %0b res %0d",
                     $realtime, what, want.msg_kind, want.msg_seq, want.msg_ack_code,
                     want.msg_dest_system, want.msg_dest_component, want.done_res,
                     want.result_code,
                     " | got kind %0d seq %0d ack %0d dst %0d/%0d done %0b res %0d",
                     got.msg_kind, got.msg_seq, got.msg_ack_code, got.msg_dest_system,
                     got.msg_dest_component, got.done_res, got.result_code);
    endtask

    // Result checker
    always @(posedge clk)
    begin : check_results
        res_t got;
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.msg_kind           = m_tdata[1:0];
            got.msg_seq            = m_tdata[17:2];
            got.msg_ack_code       = m_tdata[21:18];
            got.msg_dest_system    = m_tdata[29:22];
            got.msg_dest_component = m_tdata[37:30];
            got.result_code        = m_tdata[41:38];
            got.done_res           = m_tlast;
            if (awaited_msgs.size() == 0)
                note_fault("unexpected word", NO_MSG, got);
            else
            begin
                want = awaited_msgs[0];
                awaited_msgs.delete(0);
                if (got.msg_kind !== want.msg_kind
                    || got.msg_seq !== want.msg_seq
                    || got.msg_ack_code !== want.msg_ack_code
                    || got.msg_dest_system !== want.msg_dest_system
                    || got.msg_dest_component !== want.msg_dest_component
                    || got.done_res !== want.done_res
                    || got.result_code !== want.result_code)
                    note_fault("mismatch", want, got);
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        int     phase_end;
        logic   paused;
        upl_ev_t ev;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed words
        load_setup(16'd3, 8'hFF, 8'hFF, 8'h81, 8'd2, 16'd2);
        foreach (directed_rows[i])
            drive_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);

        // random phases, each under its own register setting
        for (int phase = 0; phase < 6; phase++)
        begin
            drain();
            src_gap_pct    = (phase < 2) ? 14 : (phase < 4) ? 45 : 0;
            sink_stall_pct = (phase < 2) ? 45 : (phase < 4) ? 14 : 0;
            case (phase)
                0: load_setup(16'd4, 8'h00, any_id(), any_id(), 8'd3, 16'd2);
                1: load_setup(16'd0, 8'hFF, 8'h00, 8'hFF, 8'd0, 16'd0);
                2: load_setup(16'hFFFF, any_id(), 8'hFF, 8'h00, 8'hFF, 16'hFFFF);
                3: load_setup(16'($urandom_range(1, 12)), any_id(), any_id(), any_id(),
                              8'($urandom_range(1, 4)), 16'($urandom_range(1, 3)));
                4: load_setup(16'd8, any_id(), any_id(), any_id(), 8'd1, 16'd1);
                default: load_setup(16'($urandom_range(0, 16)), any_id(), any_id(),
                                    any_id(), 8'($urandom_range(0, 6)),
                                    16'($urandom_range(0, 4)));
            endcase
            phase_end = words_sent + 150;
            paused = 1'b0;
            while (words_sent < phase_end)
            begin
                if ($urandom_range(0, 6) == 0)
                begin
                    // noise: any code, any field
                    repeat ($urandom_range(1, 4))
                    begin
                        ev.kind     = 3'($urandom_range(0, 7));
                        ev.seq      = any_seq();
                        ev.ack      = any_ack();
                        ev.src_sys  = any_id();
                        ev.src_comp = any_id();
                        ev.refused  = 1'($urandom_range(0, 1));
                        drive_event(ev);
                    end
                end
                else
                    run_session();
                // hold the sender until the pipe is empty once per phase
                if (!paused && words_sent > phase_end - 90)
                begin
                    drain();
                    paused = 1'b1;
                end
            end
        end

        drain();
        if (bad_words == 0 && awaited_msgs.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/mus_pkg.sv
src/mus_cfg.sv
src/mus_core.sv
src/mus_obuf.sv
src/mission_upload_sender.sv
dv/mission_upload_sender_tb.sv
